[hdl/wss_pkg.sv]
// Shared constants, register codes and helper functions of the wavefold sine shaper.
package wss_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int CH_W         = 3;
   localparam int CNT_W        = 4;
   localparam int SAMPLE_W     = 24;
   localparam int CSR_DATA_W   = 17;
   localparam int CSR_IDX_W    = 3;
   localparam int SIN_LAT      = 7;
   localparam int PIPE_LAT     = 2 * SIN_LAT + 12;

   localparam logic [16:0] ONE16 = 17'd65536;
   localparam logic [30:0] ONE30 = 31'h4000_0000;
   localparam logic [30:0] SC1   = 31'd1686629713;
   localparam logic [30:0] SC3   = 31'd693598668;
   localparam logic [30:0] SC5   = 31'd85569274;
   localparam logic [30:0] SC7   = 31'd5026996;
   localparam logic [30:0] SC9   = 31'd172272;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TONE, CSR_STEREO_WIDTH, CSR_DRIVE_MIX, CSR_FATNESS,
      CSR_DRY_MIX, CSR_OUT_GAIN, CSR_NORM_GAIN, CSR_CHANNEL_COUNT
   } csr_index_type;

   function automatic logic [16:0] cap16(input logic [16:0] v);
      return (v > ONE16) ? ONE16 : v;
   endfunction

   // Round to nearest with ties away from zero, then shift right by n.
   function automatic logic signed [65:0] rshr(input logic signed [65:0] v, input int n);
      logic [65:0] m;
      logic [65:0] r;
      m = v[65] ? 66'(-v) : 66'(v);
      r = (m + (66'd1 << (n - 1))) >> n;
      return v[65] ? -$signed(r) : $signed(r);
   endfunction

   // Q1.30 product truncated by 30 bits; callers keep the result below 2^31.
   function automatic logic [30:0] mulq30(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] p;
      p = 62'(a) * 62'(b);
      return p[60:30];
   endfunction

endpackage

[hdl/wss_req_if.sv]
// Input channel of the wavefold sine shaper: one sample and its channel index per item.
interface wss_req_if;
   logic                 valid;
   logic                 ready;
   logic signed [23:0]   sample_in;
   logic [2:0]           channel_index;
   modport source (output valid, sample_in, channel_index, input ready);
   modport sink   (input valid, sample_in, channel_index, output ready);
endinterface

[hdl/wss_rsp_if.sv]
// Result channel of the wavefold sine shaper: one processed sample per item.
interface wss_rsp_if;
   logic                 valid;
   logic                 ready;
   logic signed [23:0]   sample_out;
   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

[hdl/wss_sine.sv]
// Pipelined Q1.30 sine of x*pi/2 for x in [0,1], odd Taylor polynomial, seven stages.
module wss_sine (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] x,
   output logic [30:0] s
);
   import wss_pkg::*;

   logic [30:0] xa_ff;
   logic [30:0] z2_ff, x2_ff;
   logic [30:0] p7_ff, z3_ff, x3_ff;
   logic [30:0] p5_ff, z4_ff, x4_ff;
   logic [30:0] p3_ff, z5_ff, x5_ff;
   logic [30:0] p1_ff, x6_ff;
   logic [30:0] r_ff;
   logic [30:0] r_in;

   always_comb begin
      r_in = mulq30(p1_ff, x6_ff);
      if (r_in > ONE30) begin
         r_in = ONE30;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xa_ff <= (x > ONE30) ? ONE30 : x;
         z2_ff <= mulq30(xa_ff, xa_ff);
         x2_ff <= xa_ff;
         p7_ff <= SC7 - mulq30(SC9, z2_ff);
         z3_ff <= z2_ff;
         x3_ff <= x2_ff;
         p5_ff <= SC5 - mulq30(p7_ff, z3_ff);
         z4_ff <= z3_ff;
         x4_ff <= x3_ff;
         p3_ff <= SC3 - mulq30(p5_ff, z4_ff);
         z5_ff <= z4_ff;
         x5_ff <= x4_ff;
         p1_ff <= SC1 - mulq30(p3_ff, z5_ff);
         x6_ff <= x5_ff;
         r_ff  <= r_in;
      end
   end

   assign s = r_ff;
endmodule

[hdl/wavefold_sine_shaper.sv]
// Top level of the wavefold sine shaper: registers, spread, pre-gain, fold, shaping and mix.
// One item is accepted per cycle while the output register is empty or being taken.
// The pipeline is made of two seven-stage sine pipelines plus twelve arithmetic stages.
// The whole pipeline advances only when the output register is empty or being taken.
// Synchronous active-high reset clears the valid bits and loads the register defaults.
module wavefold_sine_shaper (
   input  logic                              clock,
   input  logic                              reset,
   wss_req_if.sink                           req_if,
   wss_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [wss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wss_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import wss_pkg::*;

   logic [16:0]        tone_ff, sw_ff, drive_ff, dry_ff, og_ff, ng_ff;
   logic signed [15:0] fat_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [32:0]        gain_ff;

   logic               en;
   logic [PIPE_LAT-1:0] vld_ff;

   logic signed [23:0] src1_ff, src2_ff, src3_ff, src4_ff, src6_ff, src7_ff;
   logic signed [23:0] src8_ff, src9_ff;
   logic signed [23:0] srcd1_ff [SIN_LAT];
   logic signed [23:0] srcd2_ff [SIN_LAT];
   logic signed [24:0] yd2_ff [SIN_LAT];
   logic [CH_W-1:0]    ch1_ff;
   logic [21:0]        num2_ff;
   logic               kneg2_ff, spread2_ff;
   logic [CNT_W-1:0]   d2_ff;
   logic [16:0]        freq3_ff;
   logic [36:0]        pregain4_ff;
   logic [42:0]        pph5_ff;
   logic [41:0]        ppl5_ff;
   logic               neg5_ff;
   logic signed [23:0] src5_ff;
   logic signed [24:0] pf6_ff, pd6_ff, y7_ff, y8_ff;
   logic signed [41:0] prod8_ff;
   logic signed [31:0] t9_ff;
   logic signed [33:0] u10_ff;
   logic signed [67:0] up11_ff;
   logic signed [23:0] out_ff;

   logic [30:0]        sin1_x, sin1_s, sin2_x, sin2_s;

   logic [CNT_W-1:0]   n_c, d_c;
   logic signed [5:0]  k_c;
   logic [4:0]         kabs_c;
   logic [23:0]        nr_c, q_c;
   logic [24:0]        recip_c;
   logic [48:0]        qprod_c;
   logic signed [25:0] freq_c;
   logic [36:0]        pregain_c;
   logic [23:0]        a_c;
   logic [60:0]        mprod_c;
   logic [31:0]        m_c;
   logic [24:0]        r_c;
   logic signed [24:0] f_c, pd_c;
   logic [16:0]        dcap_c, wcap_c;
   logic signed [65:0] ymix_c, tsh_c, umix_c, v_c;
   logic [23:0]        s23_c;
   logic signed [25:0] s23s_c, diff_c;
   logic signed [15:0] fatc_c;

   assign en           = !vld_ff[PIPE_LAT-1] || rsp_if.ready;
   assign req_if.ready = en;
   assign rsp_if.valid = vld_ff[PIPE_LAT-1];
   assign rsp_if.sample_out = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_ff  <= 17'd20972;
         sw_ff    <= 17'd24248;
         drive_ff <= 17'd0;
         fat_ff   <= 16'sd0;
         dry_ff   <= 17'd0;
         og_ff    <= 17'd26214;
         ng_ff    <= 17'd65536;
         cnt_ff   <= CNT_W'(2);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TONE:          tone_ff  <= csr_wdata;
            CSR_STEREO_WIDTH:  sw_ff    <= csr_wdata;
            CSR_DRIVE_MIX:     drive_ff <= csr_wdata;
            CSR_FATNESS:       fat_ff   <= $signed(csr_wdata[15:0]);
            CSR_DRY_MIX:       dry_ff   <= csr_wdata;
            CSR_OUT_GAIN:      og_ff    <= csr_wdata;
            CSR_NORM_GAIN:     ng_ff    <= csr_wdata;
            CSR_CHANNEL_COUNT: cnt_ff   <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      gain_ff <= 33'(34'(cap16(og_ff)) * 34'(cap16(ng_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_if.valid};
      end
   end

   always_comb begin
      n_c = cnt_ff;
      if (n_c > CNT_W'(MAX_CHANNELS)) begin
         n_c = CNT_W'(MAX_CHANNELS);
      end
      d_c    = n_c - CNT_W'(1);
      k_c    = $signed({2'b00, ch1_ff, 1'b0}) - $signed({2'b00, d_c});
      kabs_c = k_c[5] ? 5'(-k_c) : 5'(k_c);

      // The quotient by 10*d is a multiplication by a rounded-up reciprocal; it is exact
      // because the numerator stays below 2^21.
      nr_c = {1'b0, num2_ff, 1'b0} + 24'(5 * d2_ff);
      case (d2_ff)
         4'd1:    recip_c = 25'((2**28 + 9) / 10);
         4'd2:    recip_c = 25'((2**28 + 19) / 20);
         4'd3:    recip_c = 25'((2**28 + 29) / 30);
         4'd4:    recip_c = 25'((2**28 + 39) / 40);
         4'd5:    recip_c = 25'((2**28 + 49) / 50);
         4'd6:    recip_c = 25'((2**28 + 59) / 60);
         4'd7:    recip_c = 25'((2**28 + 69) / 70);
         default: recip_c = '0;
      endcase
      qprod_c = 49'(nr_c) * 49'(recip_c);
      q_c     = {3'd0, qprod_c[48:28]};
      freq_c = $signed({9'd0, tone_ff});
      if (spread2_ff) begin
         freq_c = kneg2_ff ? freq_c - $signed({2'b00, q_c}) : freq_c + $signed({2'b00, q_c});
      end
      if (freq_c < 0) begin
         freq_c = '0;
      end else if (freq_c > $signed({9'd0, ONE16})) begin
         freq_c = $signed({9'd0, ONE16});
      end

      pregain_c = (37'd100 << 30) - 37'(37'd99 * 37'(sin1_s));
      a_c       = src4_ff[23] ? 24'(-src4_ff) : 24'(src4_ff);

      mprod_c = {pph5_ff, 18'd0} + 61'(ppl5_ff) + 61'(ONE30 >> 1);
      m_c     = 32'(mprod_c[60:30]);
      r_c     = m_c[24:0];
      if (r_c > 25'd25165824) begin
         f_c = $signed(r_c) ;
      end else if (r_c > 25'd8388608) begin
         f_c = $signed(25'd16777216 - r_c);
      end else begin
         f_c = $signed(r_c);
      end
      pd_c = (m_c > 32'd8388608) ? 25'sd8388608 : $signed(25'(m_c));

      dcap_c = cap16(drive_ff);
      wcap_c = cap16(dry_ff);
      ymix_c = rshr(66'(pd6_ff) * 66'($signed({1'b0, dcap_c}))
                  + 66'(pf6_ff) * 66'($signed({1'b0, ONE16 - dcap_c})), 16);

      s23_c  = 24'((32'(sin2_s) + 32'd64) >> 7);
      s23s_c = yd2_ff[SIN_LAT-1][24] ? -$signed({2'b00, s23_c}) : $signed({2'b00, s23_c});
      diff_c = s23s_c - 26'(yd2_ff[SIN_LAT-1]);
      fatc_c = fat_ff;
      if (fatc_c > 16'sd20480) begin
         fatc_c = 16'sd20480;
      end else if (fatc_c < -16'sd20480) begin
         fatc_c = -16'sd20480;
      end

      tsh_c = rshr(66'(prod8_ff), 10);
      umix_c = rshr(66'(t9_ff) * 66'($signed({1'b0, ONE16 - wcap_c}))
                  + 66'(src9_ff) * 66'($signed({1'b0, wcap_c})), 16);
      v_c = rshr(66'(up11_ff), 32);
   end

   assign sin1_x = {ONE16 - freq3_ff, 14'd0};
   assign sin2_x = {y7_ff[24] ? 24'(-y7_ff) : 24'(y7_ff), 7'd0};

   wss_sine u_sine_pregain (.clock(clock), .en(en), .x(sin1_x), .s(sin1_s));
   wss_sine u_sine_shape   (.clock(clock), .en(en), .x(sin2_x), .s(sin2_s));

   always_ff @(posedge clock) begin
      if (en) begin
         src1_ff <= req_if.sample_in;
         ch1_ff  <= req_if.channel_index;

         src2_ff    <= src1_ff;
         num2_ff    <= 22'(22'(cap16(sw_ff)) * 22'(kabs_c));
         kneg2_ff   <= k_c[5];
         spread2_ff <= (n_c > CNT_W'(1));
         d2_ff      <= d_c;

         src3_ff  <= src2_ff;
         freq3_ff <= 17'(freq_c);

         srcd1_ff[0] <= src3_ff;
         for (int i = 1; i < SIN_LAT; i++) begin
            srcd1_ff[i] <= srcd1_ff[i-1];
         end

         src4_ff     <= srcd1_ff[SIN_LAT-1];
         pregain4_ff <= pregain_c;

         src5_ff <= src4_ff;
         neg5_ff <= src4_ff[23];
         pph5_ff <= 43'(a_c) * 43'(pregain4_ff[36:18]);
         ppl5_ff <= 42'(a_c) * 42'(pregain4_ff[17:0]);

         src6_ff <= src5_ff;
         pf6_ff  <= neg5_ff ? -f_c : f_c;
         pd6_ff  <= neg5_ff ? -pd_c : pd_c;

         src7_ff <= src6_ff;
         y7_ff   <= 25'(ymix_c);

         srcd2_ff[0] <= src7_ff;
         yd2_ff[0]   <= y7_ff;
         for (int i = 1; i < SIN_LAT; i++) begin
            srcd2_ff[i] <= srcd2_ff[i-1];
            yd2_ff[i]   <= yd2_ff[i-1];
         end

         src8_ff  <= srcd2_ff[SIN_LAT-1];
         y8_ff    <= yd2_ff[SIN_LAT-1];
         prod8_ff <= 42'(diff_c) * 42'(fatc_c);

         src9_ff <= src8_ff;
         t9_ff   <= 32'(66'(y8_ff) + tsh_c);

         u10_ff <= 34'(umix_c);

         up11_ff <= 68'(u10_ff) * 68'($signed({1'b0, gain_ff}));

         if (v_c > 66'sd8388607) begin
            out_ff <= 24'sd8388607;
         end else if (v_c < -66'sd8388608) begin
            out_ff <= -24'sd8388608;
         end else begin
            out_ff <= 24'(v_c);
         end
      end
   end
endmodule

[test/tb_wavefold_sine_shaper.sv]
// Self-checking testbench of the wavefold sine shaper: directed table, random samples and settings.
module tb_wavefold_sine_shaper;
   import wss_pkg::*;

   typedef struct {
      logic signed [23:0] sample;
      logic [2:0]         channel;
      logic               known;
      logic signed [23:0] result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   wss_req_if req_if();
   wss_rsp_if rsp_if();

   wavefold_sine_shaper u_top (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic [16:0] m_tone, m_width, m_drive, m_dry, m_gain, m_norm;
   logic signed [15:0] m_fat;
   logic [3:0] m_count;

   logic signed [23:0] expected_samples[$];
   int errors = 0;
   int rsp_checked = 0;
   bit idle_enable = 1'b1;
   bit stall_long = 1'b0;
   stim_row_type table_rows[8];

   initial begin
      req_if.valid = 1'b0;
      req_if.sample_in = '0;
      req_if.channel_index = '0;
      rsp_if.ready = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #200000000;
      $display("wavefold_sine_shaper: mismatch");
      $finish;
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("ERROR %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic longint round_shift(input longint v, input int n);
      longint mag;
      mag = v < 0 ? -v : v;
      mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
      return v < 0 ? -mag : mag;
   endfunction

   function automatic longint sine_q30(input longint x);
      longint z, p, r;
      if (x > 64'sd1073741824) x = 64'sd1073741824;
      z = (x * x) >>> 30;
      p = 172272;
      p = 5026996 - ((p * z) >>> 30);
      p = 85569274 - ((p * z) >>> 30);
      p = 693598668 - ((p * z) >>> 30);
      p = 1686629713 - ((p * z) >>> 30);
      r = (p * x) >>> 30;
      return r > 64'sd1073741824 ? 64'sd1073741824 : r;
   endfunction

   function automatic longint sat16(input logic [16:0] v);
      return v > 17'd65536 ? 65536 : longint'(v);
   endfunction

   function automatic logic signed [23:0] shape_sample(input logic signed [23:0] smp,
                                                       input logic [2:0] chan);
      longint src, n, freq, fat, drv, dry, g, d, k, num, q, gain, a, m, r, f, pf, pd, y;
      longint s, s23, t, u, v;
      bit neg;
      src = smp;
      neg = src < 0;
      n = m_count;
      freq = m_tone;
      fat = m_fat;
      drv = sat16(m_drive);
      dry = sat16(m_dry);
      g = sat16(m_gain) * sat16(m_norm);
      if (n > MAX_CHANNELS) n = MAX_CHANNELS;
      if (n > 1) begin
         d = n - 1;
         k = 2 * longint'(chan) - d;
         num = sat16(m_width) * (k < 0 ? -k : k);
         q = (2 * num + 5 * d) / (10 * d);
         freq += k < 0 ? -q : q;
      end
      if (freq < 0) freq = 0;
      if (freq > 65536) freq = 65536;
      gain = 100 * 64'sd1073741824 - 99 * sine_q30((65536 - freq) <<< 14);
      a = neg ? -src : src;
      m = (a * gain + 64'sd536870912) >>> 30;
      r = m & ((64'sd1 <<< 25) - 1);
      if (r > 3 * 8388608) f = r - 4 * 8388608;
      else if (r > 8388608) f = 2 * 8388608 - r;
      else f = r;
      pf = neg ? -f : f;
      pd = m > 8388608 ? 8388608 : m;
      if (neg) pd = -pd;
      if (fat > 20480) fat = 20480;
      if (fat < -20480) fat = -20480;
      y = round_shift(pd * drv + pf * (65536 - drv), 16);
      s = sine_q30((y < 0 ? -y : y) <<< 7);
      s23 = (s + 64) >>> 7;
      if (y < 0) s23 = -s23;
      t = y + round_shift((s23 - y) * fat, 10);
      u = round_shift(t * (65536 - dry) + src * dry, 16);
      v = round_shift(u * g, 32);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return 24'(v);
   endfunction

   task automatic write_setting(input csr_index_type idx, input logic [16:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_TONE:          m_tone = value;
         CSR_STEREO_WIDTH:  m_width = value;
         CSR_DRIVE_MIX:     m_drive = value;
         CSR_FATNESS:       m_fat = value[15:0];
         CSR_DRY_MIX:       m_dry = value;
         CSR_OUT_GAIN:      m_gain = value;
         CSR_NORM_GAIN:     m_norm = value;
         CSR_CHANNEL_COUNT: m_count = value[3:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   task automatic send_sample(input logic signed [23:0] smp, input logic [2:0] chan);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample_in <= smp;
      req_if.channel_index <= chan;
      expected_samples.insert(expected_samples.size(), shape_sample(smp, chan));
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic end_burst;
      req_if.valid <= 1'b0;
   endtask

   task automatic random_settings(input bit extreme);
      write_setting(CSR_TONE, extreme ? ($urandom_range(0, 1) ? 17'd65536 : 17'd0)
                                      : 17'($urandom_range(0, 131071)));
      write_setting(CSR_STEREO_WIDTH, 17'($urandom_range(0, 131071)));
      write_setting(CSR_DRIVE_MIX, 17'($urandom_range(0, 1) ? $urandom_range(0, 65536)
                                                              : $urandom_range(0, 131071)));
      write_setting(CSR_FATNESS, 17'($urandom_range(0, 65535)));
      write_setting(CSR_DRY_MIX, 17'($urandom_range(0, 131071)));
      write_setting(CSR_OUT_GAIN, 17'($urandom_range(0, 131071)));
      write_setting(CSR_NORM_GAIN, 17'($urandom_range(0, 131071)));
      write_setting(CSR_CHANNEL_COUNT, 17'($urandom_range(0, 15)));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_samples.size() == 0) begin
            report("unexpected item", rsp_if.sample_out, 0);
         end else begin
            if (rsp_if.sample_out !== expected_samples[0])
               report("sample_out", rsp_if.sample_out, expected_samples[0]);
            void'(expected_samples.pop_front());
         end
         rsp_checked++;
      end
   end

   initial begin
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_long) begin
            rsp_if.ready <= 1'b0;
            hold = 0;
            while (hold < 200) begin
               @(posedge clock);
               hold++;
            end
            stall_long = 1'b0;
         end
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      logic signed [23:0] got;
      m_tone = 17'd20972; m_width = 17'd24248; m_drive = '0; m_fat = '0;
      m_dry = '0; m_gain = 17'd26214; m_norm = 17'd65536; m_count = 4'd2;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      table_rows[0] = '{24'sd0, 3'd0, 1'b1, 24'sd0};
      table_rows[1] = '{24'sd0, 3'd7, 1'b1, 24'sd0};
      table_rows[2] = '{24'sh7FFFFF, 3'd0, 1'b0, 24'sd0};
      table_rows[3] = '{-24'sd8388608, 3'd1, 1'b0, 24'sd0};
      table_rows[4] = '{24'sd1, 3'd7, 1'b0, 24'sd0};
      table_rows[5] = '{-24'sd1, 3'd3, 1'b0, 24'sd0};
      table_rows[6] = '{24'sd4194304, 3'd5, 1'b0, 24'sd0};
      table_rows[7] = '{-24'sd123456, 3'd2, 1'b0, 24'sd0};
      foreach (table_rows[i]) send_sample(table_rows[i].sample, table_rows[i].channel);
      end_burst();
      drain();
      foreach (table_rows[i])
         if (table_rows[i].known) begin
            got = shape_sample(table_rows[i].sample, table_rows[i].channel);
            if (got !== table_rows[i].result) report("table row", got, table_rows[i].result);
         end

      // Full gain, hard clip and full fattening drive the output into saturation.
      write_setting(CSR_TONE, 17'd65536);
      write_setting(CSR_DRIVE_MIX, 17'd131071);
      write_setting(CSR_FATNESS, 17'h0B000);
      write_setting(CSR_OUT_GAIN, 17'd131071);
      write_setting(CSR_NORM_GAIN, 17'd65536);
      write_setting(CSR_DRY_MIX, 17'd0);
      write_setting(CSR_CHANNEL_COUNT, 17'd15);
      write_setting(CSR_STEREO_WIDTH, 17'd65536);
      send_sample(24'sh7FFFFF, 3'd7);
      send_sample(-24'sd8388608, 3'd0);
      send_sample(24'sd4000000, 3'd4);
      end_burst();
      drain();
      write_setting(CSR_FATNESS, 17'h05000);
      write_setting(CSR_DRY_MIX, 17'd65536);
      write_setting(CSR_CHANNEL_COUNT, 17'd0);
      write_setting(CSR_TONE, 17'd0);
      send_sample(24'sh7FFFFF, 3'd1);
      send_sample(-24'sd8388608, 3'd6);
      end_burst();
      drain();
      write_setting(CSR_CHANNEL_COUNT, 17'd1);
      send_sample(24'sd2222222, 3'd2);
      end_burst();
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         random_settings(phase < 2);
         if (phase == 3) stall_long = 1'b1;
         if (phase == 7) idle_enable = 1'b0;
         for (int i = 0; i < 75; i++)
            send_sample(24'($urandom_range(0, 24'hFFFFFF)), 3'($urandom_range(0, 7)));
         end_burst();
         drain();
      end

      if (errors == 0) begin
         $display("wavefold_sine_shaper: match");
      end else begin
         $display("wavefold_sine_shaper: mismatch");
      end
      $finish;
   end

endmodule
